// ===== rtl/srdm_pkg.sv =====
// Shared types and constants for the sorted read duplicate marker.
`default_nettype none

package srdm_pkg;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int TOL_BITS      = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_OUTER = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_TOL   = 2'd1;

    typedef struct packed {
        logic                outer_coords_only;
        logic [TOL_BITS-1:0] coord_tolerance;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/srdm_rec_if.sv =====
// Record request channel: valid/ready handshake with one aligned read record.
`default_nettype none

interface srdm_rec_if #(
    parameter int COORD_BITS = 32
) ();
    logic                  valid;
    logic                  ready;
    logic                  first_record;
    logic                  reverse_strand;
    logic [COORD_BITS-1:0] start_coord;
    logic [COORD_BITS-1:0] end_coord;
    logic                  is_trimmed;

    modport source (
        output valid, first_record, reverse_strand, start_coord, end_coord, is_trimmed,
        input  ready
    );
    modport sink (
        input  valid, first_record, reverse_strand, start_coord, end_coord, is_trimmed,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/srdm_res_if.sv =====
// Result request channel: valid/ready handshake with the unique/duplicate mark.
`default_nettype none

interface srdm_res_if ();
    logic valid;
    logic ready;
    logic uniq_flag;

    modport source (
        output valid, uniq_flag,
        input  ready
    );
    modport sink (
        input  valid, uniq_flag,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/srdm_cfg.sv =====
// Configuration register file: mode bit and coordinate tolerance.
`default_nettype none

module srdm_cfg (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [srdm_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [srdm_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata,
    output srdm_pkg::t_cfg                          o_cfg
);

    srdm_pkg::t_cfg r_cfg;
    srdm_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                srdm_pkg::CFG_IDX_OUTER: n_cfg.outer_coords_only = i_cfg_wdata[0];
                srdm_pkg::CFG_IDX_TOL:
                    n_cfg.coord_tolerance = i_cfg_wdata[srdm_pkg::TOL_BITS-1:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/srdm_classify.sv =====
// Duplicate decision for one record against the current reference alignment.
`default_nettype none

module srdm_classify #(
    parameter int COORD_BITS = 32
) (
    input  wire srdm_pkg::t_cfg         i_cfg,
    input  wire logic                   i_ref_strand,
    input  wire logic [COORD_BITS-1:0]  i_ref_start,
    input  wire logic [COORD_BITS-1:0]  i_ref_end,
    input  wire logic                   i_first,
    input  wire logic                   i_strand,
    input  wire logic [COORD_BITS-1:0]  i_start,
    input  wire logic [COORD_BITS-1:0]  i_end,
    input  wire logic                   i_trimmed,
    output logic                        o_unique,
    output logic                        o_take_ref
);

    localparam int CMP_BITS = (COORD_BITS > srdm_pkg::TOL_BITS) ? COORD_BITS
                                                                 : srdm_pkg::TOL_BITS;

    logic [COORD_BITS:0]   start_ab;
    logic [COORD_BITS:0]   start_ba;
    logic [COORD_BITS:0]   end_ab;
    logic [COORD_BITS:0]   end_ba;
    logic [COORD_BITS-1:0] start_diff;
    logic [COORD_BITS-1:0] end_diff;
    logic [CMP_BITS-1:0]   tol_ext;
    logic                  start_near;
    logic                  end_near;
    logic                  near_dup;
    logic                  anchor_match;

    // Absolute differences: borrow out of a-b picks b-a.
    assign start_ab   = {1'b0, i_start} - {1'b0, i_ref_start};
    assign start_ba   = {1'b0, i_ref_start} - {1'b0, i_start};
    assign end_ab     = {1'b0, i_end} - {1'b0, i_ref_end};
    assign end_ba     = {1'b0, i_ref_end} - {1'b0, i_end};
    assign start_diff = start_ab[COORD_BITS] ? start_ba[COORD_BITS-1:0]
                                             : start_ab[COORD_BITS-1:0];
    assign end_diff   = end_ab[COORD_BITS] ? end_ba[COORD_BITS-1:0]
                                           : end_ab[COORD_BITS-1:0];

    assign tol_ext    = CMP_BITS'(i_cfg.coord_tolerance);
    assign start_near = CMP_BITS'(start_diff) <= tol_ext;
    assign end_near   = CMP_BITS'(end_diff) <= tol_ext;
    assign near_dup   = (i_strand == i_ref_strand) && start_near && end_near;

    // Forward reads anchor on start, reverse reads on end.
    assign anchor_match = i_strand ? (i_end == i_ref_end) : (i_start == i_ref_start);

    always_comb begin
        o_take_ref = 1'b1;
        o_unique   = 1'b1;
        if (i_first) begin
            o_unique = 1'b1;
        end else if (near_dup) begin
            o_unique   = 1'b0;
            o_take_ref = 1'b0;
        end else if (i_cfg.outer_coords_only) begin
            o_unique = 1'b1;
        end else begin
            o_unique = !(anchor_match && !i_trimmed);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sorted_read_duplicate_marker.sv =====
// Top level of the sorted read duplicate marker.
// Marks each record of a sorted alignment stream as unique (1) or duplicate (0) and
// takes one record per cycle while the result side does not stall. A record is captured
// in an input register, compared combinationally against the reference alignment (four
// subtracts, two compares, an anchor equality check), and its mark moves into the result
// register once it frees up. Unless the record is a near duplicate, the reference is
// updated in the same cycle, so the next record sees it without a bubble. Configuration
// writes are taken at any cycle and should be issued only while the block is idle.
`default_nettype none

module sorted_read_duplicate_marker #(
    parameter int COORD_BITS = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [srdm_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [srdm_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata,
    srdm_rec_if.sink                                i_rec,
    srdm_res_if.source                              o_res
);

    srdm_pkg::t_cfg cfg;

    logic                  r_in_valid;
    logic                  r_in_first;
    logic                  r_in_strand;
    logic [COORD_BITS-1:0] r_in_start;
    logic [COORD_BITS-1:0] r_in_end;
    logic                  r_in_trimmed;

    logic                  r_ref_strand;
    logic [COORD_BITS-1:0] r_ref_start;
    logic [COORD_BITS-1:0] r_ref_end;

    logic                  r_out_valid;
    logic                  r_out_unique;

    logic                  advance;
    logic                  in_take;
    logic                  move;
    logic                  unique_mark;
    logic                  take_ref;

    srdm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .o_cfg      (cfg)
    );

    srdm_classify #(
        .COORD_BITS(COORD_BITS)
    ) u_classify (
        .i_cfg       (cfg),
        .i_ref_strand(r_ref_strand),
        .i_ref_start (r_ref_start),
        .i_ref_end   (r_ref_end),
        .i_first     (r_in_first),
        .i_strand    (r_in_strand),
        .i_start     (r_in_start),
        .i_end       (r_in_end),
        .i_trimmed   (r_in_trimmed),
        .o_unique    (unique_mark),
        .o_take_ref  (take_ref)
    );

    // Result register frees up when empty or being taken this cycle.
    assign advance     = !r_out_valid || o_res.ready;
    assign i_rec.ready = !r_in_valid || advance;
    assign in_take     = i_rec.valid && i_rec.ready;
    assign move        = r_in_valid && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_ref_strand <= 1'b0;
            r_ref_start  <= '0;
            r_ref_end    <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (move && take_ref) begin
                r_ref_strand <= r_in_strand;
                r_ref_start  <= r_in_start;
                r_ref_end    <= r_in_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_first   <= i_rec.first_record;
            r_in_strand  <= i_rec.reverse_strand;
            r_in_start   <= i_rec.start_coord;
            r_in_end     <= i_rec.end_coord;
            r_in_trimmed <= i_rec.is_trimmed;
        end
        if (move) begin
            r_out_unique <= unique_mark;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.uniq_flag = r_out_unique;

endmodule

`default_nettype wire

// ===== rtl/srdm_checker.sv =====
// Port-level checks for the sorted read duplicate marker, bound to the top level.
`default_nettype none

module srdm_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_out_unique
);

    logic in_accept;
    assign in_accept = i_in_valid && i_in_ready;

    // No result survives a reset.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // With the result register empty, the input must be ready for a new request.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while result register empty");

    // A fresh result always comes from an accepted request held in the input register.
    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(in_accept, 2))
        else $error("result without a matching request");

    // A stalled result holds until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_unique))
        else $error("stalled result dropped or changed");

endmodule

bind sorted_read_duplicate_marker srdm_checker u_srdm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_rec.valid),
    .i_in_ready  (i_rec.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_unique(o_res.uniq_flag)
);

`default_nettype wire

// ===== sim/tb_sorted_read_duplicate_marker.sv =====
// Testbench for sorted_read_duplicate_marker: random records against a behavioral predictor.
`timescale 1ns / 1ps

module tb_sorted_read_duplicate_marker;

    localparam int COORD_BITS = 32;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [srdm_pkg::CFG_IDX_BITS-1:0] CFG_IDX_SPARE_LO = 2'd2;
    localparam logic [srdm_pkg::CFG_IDX_BITS-1:0] CFG_IDX_SPARE_HI = 2'd3;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic   first_record;
        logic   reverse_strand;
        t_coord start_coord;
        t_coord end_coord;
        logic   is_trimmed;
    } t_rec;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_cfg_we;
    logic [srdm_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [srdm_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata;

    srdm_rec_if #(.COORD_BITS(COORD_BITS)) rec_ch ();
    srdm_res_if res_ch ();

    sorted_read_duplicate_marker #(
        .COORD_BITS(COORD_BITS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_rec      (rec_ch.sink),
        .o_res      (res_ch.source)
    );

    // shadow configuration and reference alignment
    logic          cfg_outer;
    logic [15:0]   cfg_tol;
    logic          held_strand;
    t_coord        held_start;
    t_coord        held_end;

    t_rec          records_todo[$];
    logic          marks_due[$];
    t_rec          cur;
    int unsigned   send_gap;
    int unsigned   send_calm;
    int unsigned   recv_stall;
    int unsigned   recv_calm;
    int unsigned   mismatches;
    int unsigned   records_taken;
    int unsigned   dups_seen;
    int unsigned   uniques_seen;
    int unsigned   settings_used;
    int unsigned   cycles;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predicted mark for one record; moves the held reference like the block does.
    function automatic logic mark_record(input t_rec r);
        t_coord ds;
        t_coord de;
        logic   uniq;
        ds = (r.start_coord >= held_start) ? r.start_coord - held_start
                                           : held_start - r.start_coord;
        de = (r.end_coord >= held_end) ? r.end_coord - held_end : held_end - r.end_coord;
        if (r.first_record) begin
            uniq = 1'b1;
        end else if (r.reverse_strand == held_strand && ds <= cfg_tol && de <= cfg_tol) begin
            return 1'b0;  // near duplicate keeps the reference
        end else if (cfg_outer) begin
            uniq = 1'b1;
        end else if (r.reverse_strand ? (r.end_coord == held_end)
                                      : (r.start_coord == held_start)) begin
            uniq = r.is_trimmed;
        end else begin
            uniq = 1'b1;
        end
        held_strand = r.reverse_strand;
        held_start  = r.start_coord;
        held_end    = r.end_coord;
        return uniq;
    endfunction

    // Wait length for one request; now and then a calm stretch with no waits at all.
    function automatic int unsigned pick_wait(inout int unsigned calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm = $urandom_range(20, 60);
        return $urandom_range(0, 19);
    endfunction

    function automatic t_coord nudge(input t_coord c, input int unsigned reach);
        t_coord d;
        d = t_coord'($urandom_range(0, reach));
        return $urandom_range(0, 1) ? c + d : c - d;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rec_ch.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (rec_ch.valid && rec_ch.ready) begin
                marks_due.push_back(mark_record(cur));
                records_taken++;
            end
            if (!rec_ch.valid || rec_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    rec_ch.valid <= 1'b0;
                end else if (records_todo.size() > 0) begin
                    cur = records_todo.pop_front();
                    rec_ch.valid          <= 1'b1;
                    rec_ch.first_record   <= cur.first_record;
                    rec_ch.reverse_strand <= cur.reverse_strand;
                    rec_ch.start_coord    <= cur.start_coord;
                    rec_ch.end_coord      <= cur.end_coord;
                    rec_ch.is_trimmed     <= cur.is_trimmed;
                    send_gap = pick_wait(send_calm);
                end else begin
                    rec_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (res_ch.uniq_flag) uniques_seen++;
                else dups_seen++;
                if (marks_due.size() == 0) begin
                    report_mismatch($sformatf("mark %b with no record pending",
                                              res_ch.uniq_flag));
                end else if (marks_due[0] !== res_ch.uniq_flag) begin
                    report_mismatch($sformatf("uniq_flag got %b want %b",
                                              res_ch.uniq_flag, marks_due[0]));
                    void'(marks_due.pop_front());
                end else begin
                    void'(marks_due.pop_front());
                end
                recv_stall = pick_wait(recv_calm);
            end
            if (recv_stall > 0) begin
                recv_stall--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d marks outstanding", cycles, marks_due.size());
            $display("FAIL sorted_read_duplicate_marker");
            $finish;
        end
    end

    task automatic wait_idle();
        do @(negedge i_clk);
        while (records_todo.size() != 0 || rec_ch.valid || marks_due.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [srdm_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [srdm_pkg::CFG_DATA_BITS-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        if (idx == srdm_pkg::CFG_IDX_OUTER) cfg_outer = data[0];
        else if (idx == srdm_pkg::CFG_IDX_TOL) cfg_tol = data;
    endtask

    task automatic apply_setting(input logic outer, input logic [15:0] tol);
        wait_idle();
        write_reg(CFG_IDX_SPARE_LO, 16'($urandom));
        write_reg(srdm_pkg::CFG_IDX_OUTER, {15'($urandom), outer});
        write_reg(srdm_pkg::CFG_IDX_TOL, tol);
        write_reg(CFG_IDX_SPARE_HI, 16'($urandom));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        settings_used++;
    endtask

    task automatic push_rec(input logic first, input logic strand, input t_coord s,
                            input t_coord e, input logic trimmed);
        records_todo.push_back('{first, strand, s, e, trimmed});
    endtask

    // Record sets: a first record followed by near copies, anchor sharers and noise.
    task automatic queue_sets(input int unsigned count);
        int unsigned n;
        int unsigned reach;
        t_rec        base;
        t_rec        r;
        n = 0;
        while (n < count) begin
            base.first_record   = 1'b1;
            base.reverse_strand = 1'($urandom_range(0, 1));
            base.is_trimmed     = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 5))
                0: base.start_coord = t_coord'($urandom_range(0, 3));
                1: base.start_coord = '1 - t_coord'($urandom_range(0, 3));
                default: base.start_coord = t_coord'($urandom);
            endcase
            base.end_coord = base.start_coord + t_coord'($urandom_range(0, 500));
            records_todo.push_back(base);
            n++;
            repeat ($urandom_range(0, 7)) begin
                r = base;
                r.first_record = 1'b0;
                r.is_trimmed   = 1'($urandom_range(0, 1));
                reach = ($urandom_range(0, 3) == 0) ? cfg_tol + 1 : cfg_tol;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        r.start_coord = nudge(base.start_coord, reach);
                        r.end_coord   = nudge(base.end_coord, reach);
                    end
                    4, 5, 6: begin
                        r.reverse_strand = 1'($urandom_range(0, 1));
                        if (r.reverse_strand)
                            r.start_coord = nudge(base.start_coord, 2 * reach + 10);
                        else
                            r.end_coord = nudge(base.end_coord, 2 * reach + 10);
                    end
                    7: r.reverse_strand = ~base.reverse_strand;
                    8: begin
                        r.first_record   = 1'($urandom_range(0, 1));
                        r.reverse_strand = 1'($urandom_range(0, 1));
                        r.start_coord    = t_coord'($urandom);
                        r.end_coord      = t_coord'($urandom);
                    end
                    default: ;
                endcase
                records_todo.push_back(r);
                n++;
                if (r.start_coord != base.start_coord || r.end_coord != base.end_coord
                        || r.reverse_strand != base.reverse_strand)
                    if ($urandom_range(0, 1)) base = r;
            end
        end
    endtask

    initial begin
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = '0;
        i_cfg_wdata           = '0;
        rec_ch.valid          = 1'b0;
        rec_ch.first_record   = 1'b0;
        rec_ch.reverse_strand = 1'b0;
        rec_ch.start_coord    = '0;
        rec_ch.end_coord      = '0;
        rec_ch.is_trimmed     = 1'b0;
        res_ch.ready          = 1'b0;
        cfg_outer             = 1'b0;
        cfg_tol               = '0;
        held_strand           = 1'b0;
        held_start            = '0;
        held_end              = '0;
        send_calm             = 0;
        recv_calm             = 0;
        mismatches            = 0;
        records_taken         = 0;
        dups_seen             = 0;
        uniques_seen          = 0;
        settings_used         = 1;
        cycles                = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings; records before any first record meet the zero reference
        push_rec(1'b0, 1'b0, 32'd0, 32'd0, 1'b0);
        push_rec(1'b0, 1'b1, 32'd0, 32'd0, 1'b1);
        push_rec(1'b1, 1'b0, '1, '1, 1'b0);
        push_rec(1'b0, 1'b0, '1, 32'd0, 1'b0);
        push_rec(1'b0, 1'b1, 32'd5, 32'd0, 1'b0);
        push_rec(1'b0, 1'b1, 32'd5, 32'd0, 1'b1);

        // outer coordinates only, widest tolerance: edges of the window
        apply_setting(1'b1, 16'hFFFF);
        push_rec(1'b1, 1'b0, 32'd1000, 32'd2000, 1'b0);
        push_rec(1'b0, 1'b0, 32'd66535, 32'd67535, 1'b0);
        push_rec(1'b0, 1'b0, 32'd66536, 32'd2000, 1'b0);
        push_rec(1'b0, 1'b1, 32'd66536, 32'd2000, 1'b0);
        push_rec(1'b1, 1'b1, '1, '1, 1'b1);
        push_rec(1'b0, 1'b1, 32'd0, '1, 1'b0);
        push_rec(1'b0, 1'b0, 32'd0, 32'd0, 1'b0);

        // anchor rule with trimmed and untrimmed records on both strands
        apply_setting(1'b0, 16'd1);
        push_rec(1'b1, 1'b0, 32'd100, 32'd200, 1'b0);
        push_rec(1'b0, 1'b0, 32'd101, 32'd199, 1'b1);
        push_rec(1'b0, 1'b0, 32'd100, 32'd5000, 1'b1);
        push_rec(1'b0, 1'b0, 32'd100, 32'd9, 1'b0);
        push_rec(1'b0, 1'b1, 32'd7, 32'd9, 1'b0);
        push_rec(1'b0, 1'b1, 32'd7, 32'd9, 1'b1);
        push_rec(1'b0, 1'b1, 32'd3, 32'd9, 1'b1);

        apply_setting(1'b0, 16'd0);
        queue_sets(190);
        apply_setting(1'b1, 16'd0);
        queue_sets(190);
        apply_setting(1'b0, 16'd3);
        queue_sets(190);
        apply_setting(1'b1, 16'd200);
        queue_sets(190);
        apply_setting(1'b0, 16'hFFFF);
        queue_sets(190);
        apply_setting(1'b1, 16'hFFFF);
        queue_sets(190);
        apply_setting(1'b0, 16'($urandom));
        queue_sets(190);
        apply_setting(1'b1, 16'd1);
        queue_sets(190);

        wait_idle();
        repeat (10) @(negedge i_clk);
        $display("%0d records marked under %0d settings: %0d unique, %0d duplicate",
                 records_taken, settings_used, uniques_seen, dups_seen);
        $display("%0d mismatches in %0d cycles", mismatches, cycles);
        if (mismatches == 0) begin
            $display("PASS sorted_read_duplicate_marker");
        end else begin
            $display("FAIL sorted_read_duplicate_marker");
        end
        $finish;
    end

endmodule
